>>> design/ifs_chaos_game_step_macros.svh
// Assertion macros for the chaos-game step block.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef IFS_CHAOS_GAME_STEP_MACROS_SVH
`define IFS_CHAOS_GAME_STEP_MACROS_SVH

// Clocked check, off while reset is asserted.
`define IFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define IFS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> design/ifs_pkg.sv
// Shared types, constants and register codes for the chaos-game step block.
// No dependencies; every other file of the block but the macros header refers to it by scoped names.
`timescale 1ns / 1ps

package ifs_pkg;

  localparam int MAX_MAPS        = 4;
  localparam int COEF_BITS       = 16;
  localparam int POINT_BITS      = 24;

  localparam int NUM_SLOTS       = 4;
  localparam int MAP_IDX_BITS    = 2;
  localparam int SLOT_BITS       = 16;
  localparam int LIN_BITS        = 64;
  localparam int OP_BITS         = 49;
  localparam int PROB_LSB        = 32;
  localparam int PROB_BITS       = 17;
  localparam int RAND_BITS       = 16;
  localparam int PSUM_BITS       = PROB_BITS + 2;
  localparam int POINT_FRAC_BITS = 16;
  localparam int FRAC_BITS       = COEF_BITS - 2;

  localparam int CFG_IDX_BITS    = 4;
  localparam int CFG_DATA_BITS   = 64;

  localparam int PROD_BITS       = COEF_BITS + POINT_BITS;
  localparam int ACC_BITS        = PROD_BITS + 2;

  localparam logic signed [ACC_BITS-1:0] ACC_ROUND =
    ACC_BITS'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [ACC_BITS-1:0] ACC_PT_MAX =
    ACC_BITS'((64'sd1 <<< (POINT_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_BITS-1:0] ACC_PT_MIN =
    ACC_BITS'(-(64'sd1 <<< (POINT_BITS - 1)));

  typedef logic [LIN_BITS-1:0]          lin_t;
  typedef logic [OP_BITS-1:0]           op_t;
  typedef logic signed [POINT_BITS-1:0] point_t;

  typedef enum logic [1:0] {
    CMD_STEP    = 2'd0,
    CMD_BURN    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MAP0_LINEAR = 4'd0,
    REG_MAP0_OFFSET = 4'd1,
    REG_MAP1_LINEAR = 4'd2,
    REG_MAP1_OFFSET = 4'd3,
    REG_MAP2_LINEAR = 4'd4,
    REG_MAP2_OFFSET = 4'd5,
    REG_MAP3_LINEAR = 4'd6,
    REG_MAP3_OFFSET = 4'd7
  } reg_idx_e;

  typedef struct packed {
    logic                    hit;
    logic [MAP_IDX_BITS-1:0] idx;
  } pick_t;

endpackage

>>> design/ifs_chan_if.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on ifs_pkg for field widths.
`timescale 1ns / 1ps

interface ifs_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             command;
  logic [ifs_pkg::RAND_BITS-1:0]          rand_frac;
  logic [ifs_pkg::MAP_IDX_BITS-1:0]       burn_map;
  logic signed [ifs_pkg::POINT_BITS-1:0]  start_x;
  logic signed [ifs_pkg::POINT_BITS-1:0]  start_y;

  modport source (output valid, command, rand_frac, burn_map, start_x, start_y,
                  input ready);
  modport sink   (input valid, command, rand_frac, burn_map, start_x, start_y,
                  output ready);
endinterface

interface ifs_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [ifs_pkg::POINT_BITS-1:0]  point_x;
  logic signed [ifs_pkg::POINT_BITS-1:0]  point_y;
  logic [ifs_pkg::MAP_IDX_BITS-1:0]       map_index;
  logic signed [ifs_pkg::POINT_BITS-1:0]  min_x;
  logic signed [ifs_pkg::POINT_BITS-1:0]  max_x;
  logic signed [ifs_pkg::POINT_BITS-1:0]  min_y;
  logic signed [ifs_pkg::POINT_BITS-1:0]  max_y;

  modport source (output valid, point_x, point_y, map_index, min_x, max_x, min_y, max_y,
                  input ready);
  modport sink   (input valid, point_x, point_y, map_index, min_x, max_x, min_y, max_y,
                  output ready);
endinterface

>>> design/ifs_cfg_regs.sv
// Map coefficient and probability registers with a plain write port.
// Depends on ifs_pkg.
`timescale 1ns / 1ps

module ifs_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ifs_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [ifs_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  output ifs_pkg::lin_t                     lin_o [ifs_pkg::NUM_SLOTS],
  output ifs_pkg::op_t                      op_o  [ifs_pkg::NUM_SLOTS]
);

  ifs_pkg::lin_t lin_q [ifs_pkg::NUM_SLOTS];
  ifs_pkg::lin_t lin_d [ifs_pkg::NUM_SLOTS];
  ifs_pkg::op_t  op_q  [ifs_pkg::NUM_SLOTS];
  ifs_pkg::op_t  op_d  [ifs_pkg::NUM_SLOTS];
  ifs_pkg::lin_t wr_lin;
  ifs_pkg::op_t  wr_op;

  assign wr_lin = cfg_data_i[ifs_pkg::LIN_BITS-1:0];
  assign wr_op  = cfg_data_i[ifs_pkg::OP_BITS-1:0];

  always_comb begin
    lin_d = lin_q;
    op_d  = op_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        ifs_pkg::REG_MAP0_LINEAR: lin_d[0] = wr_lin;
        ifs_pkg::REG_MAP0_OFFSET: op_d[0]  = wr_op;
        ifs_pkg::REG_MAP1_LINEAR: lin_d[1] = wr_lin;
        ifs_pkg::REG_MAP1_OFFSET: op_d[1]  = wr_op;
        ifs_pkg::REG_MAP2_LINEAR: lin_d[2] = wr_lin;
        ifs_pkg::REG_MAP2_OFFSET: op_d[2]  = wr_op;
        ifs_pkg::REG_MAP3_LINEAR: lin_d[3] = wr_lin;
        ifs_pkg::REG_MAP3_OFFSET: op_d[3]  = wr_op;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ifs_pkg::NUM_SLOTS; k++) begin
        lin_q[k] <= '0;
        op_q[k]  <= '0;
      end
    end else begin
      lin_q <= lin_d;
      op_q  <= op_d;
    end
  end

  assign lin_o = lin_q;
  assign op_o  = op_q;

endmodule

>>> design/ifs_map_select.sv
// Map selection: first map whose running probability sum exceeds the fraction.
// Depends on ifs_pkg.
`timescale 1ns / 1ps

module ifs_map_select (
  input  ifs_pkg::op_t                   op_i [ifs_pkg::NUM_SLOTS],
  input  logic [ifs_pkg::RAND_BITS-1:0]  rand_frac_i,
  output ifs_pkg::pick_t                 pick_o
);

  logic [ifs_pkg::PSUM_BITS-1:0] sum;
  logic [ifs_pkg::PSUM_BITS-1:0] r_ext;

  assign r_ext = ifs_pkg::PSUM_BITS'(rand_frac_i);

  always_comb begin
    sum    = '0;
    pick_o = '0;
    for (int j = 0; j < ifs_pkg::MAX_MAPS; j++) begin
      sum = sum + ifs_pkg::PSUM_BITS'(op_i[j][ifs_pkg::PROB_LSB +: ifs_pkg::PROB_BITS]);
      if (!pick_o.hit && (r_ext < sum)) begin
        pick_o.hit = 1'b1;
        pick_o.idx = ifs_pkg::MAP_IDX_BITS'(j);
      end
    end
  end

endmodule

>>> design/ifs_affine.sv
// One output coordinate of an affine map: m0*x + m1*y + off, rounded half up
// to the point format and saturated. Depends on ifs_pkg.
`timescale 1ns / 1ps

module ifs_affine (
  input  logic [ifs_pkg::SLOT_BITS-1:0] m0_i,
  input  logic [ifs_pkg::SLOT_BITS-1:0] m1_i,
  input  logic [ifs_pkg::SLOT_BITS-1:0] off_i,
  input  ifs_pkg::point_t               x_i,
  input  ifs_pkg::point_t               y_i,
  output ifs_pkg::point_t               p_o
);

  logic signed [ifs_pkg::COEF_BITS-1:0] m0, m1, off;
  logic signed [ifs_pkg::PROD_BITS-1:0] prod0, prod1;
  logic signed [ifs_pkg::ACC_BITS-1:0]  acc, rnd, shr;

  assign m0  = signed'(m0_i[ifs_pkg::COEF_BITS-1:0]);
  assign m1  = signed'(m1_i[ifs_pkg::COEF_BITS-1:0]);
  assign off = signed'(off_i[ifs_pkg::COEF_BITS-1:0]);

  assign prod0 = m0 * x_i;
  assign prod1 = m1 * y_i;

  assign acc = ifs_pkg::ACC_BITS'(prod0) + ifs_pkg::ACC_BITS'(prod1)
             + (ifs_pkg::ACC_BITS'(off) <<< ifs_pkg::POINT_FRAC_BITS);
  assign rnd = acc + ifs_pkg::ACC_ROUND;
  assign shr = rnd >>> ifs_pkg::FRAC_BITS;

  always_comb begin
    if (shr > ifs_pkg::ACC_PT_MAX) begin
      p_o = ifs_pkg::ACC_PT_MAX[ifs_pkg::POINT_BITS-1:0];
    end else if (shr < ifs_pkg::ACC_PT_MIN) begin
      p_o = ifs_pkg::ACC_PT_MIN[ifs_pkg::POINT_BITS-1:0];
    end else begin
      p_o = shr[ifs_pkg::POINT_BITS-1:0];
    end
  end

endmodule

>>> design/ifs_chaos_game_step.sv
// Top level of the chaos-game step block: input register, point and box state,
// result register. Depends on ifs_pkg, ifs_chan_if, ifs_cfg_regs, ifs_map_select,
// ifs_affine and ifs_chaos_game_step_macros.svh.
//
//   channel   dir  handshake          payload
//   in_i      in   valid/ready        command, rand_frac, burn_map, start_x, start_y
//   out_o     out  valid/ready        point_x, point_y, map_index, min/max x/y
//   cfg       in   cfg_we_i (write)   cfg_idx_i, cfg_data_i
//
// One word per cycle unless a waiting result stalls it: a word sits in the input register, where map
// select, the two affine lanes and the box update run, then its result (if any)
// sits in the output register, whose valid flag drives out_o.valid.
// The point feedback through the affine lanes forms the loop from the point registers back to themselves.
// Reset clears the map registers, point, box and both valid flags.
// A waiting result stalls only a following step that emits.
`timescale 1ns / 1ps
`include "ifs_chaos_game_step_macros.svh"

module ifs_chaos_game_step (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ifs_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [ifs_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  ifs_in_if.sink                            in_i,
  ifs_out_if.source                         out_o
);

  ifs_pkg::lin_t   lin [ifs_pkg::NUM_SLOTS];
  ifs_pkg::op_t    op  [ifs_pkg::NUM_SLOTS];

  logic                                in_valid_q, in_valid_d;
  ifs_pkg::cmd_e                       cmd_q;
  logic [ifs_pkg::RAND_BITS-1:0]       rand_q;
  logic [ifs_pkg::MAP_IDX_BITS-1:0]    burn_q;
  ifs_pkg::point_t                     sx_q, sy_q;

  ifs_pkg::point_t cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  ifs_pkg::point_t bmin_x_q, bmin_x_d, bmax_x_q, bmax_x_d;
  ifs_pkg::point_t bmin_y_q, bmin_y_d, bmax_y_q, bmax_y_d;
  logic            started_q, started_d;

  logic                                out_valid_q, out_valid_d;
  ifs_pkg::point_t                     op_x_q, op_y_q;
  ifs_pkg::point_t                     omin_x_q, omax_x_q, omin_y_q, omax_y_q;
  logic [ifs_pkg::MAP_IDX_BITS-1:0]    oidx_q;

  ifs_pkg::pick_t                      pick;
  logic [ifs_pkg::MAP_IDX_BITS-1:0]    sel_idx;
  ifs_pkg::lin_t                       lin_sel;
  ifs_pkg::op_t                        op_sel;
  ifs_pkg::point_t                     nx, ny;
  logic                                burn_ok;
  logic                                emit, out_free, advance, in_fire;
  logic                                pt_in_box, held, restart_go, load_out;

  ifs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .lin_o      (lin),
    .op_o       (op)
  );

  ifs_map_select u_sel (
    .op_i        (op),
    .rand_frac_i (rand_q),
    .pick_o      (pick)
  );

  assign sel_idx = (cmd_q == ifs_pkg::CMD_BURN) ? burn_q : pick.idx;
  assign lin_sel = lin[sel_idx];
  assign op_sel  = op[sel_idx];
  assign burn_ok = ({1'b0, burn_q} < (ifs_pkg::MAP_IDX_BITS + 1)'(ifs_pkg::MAX_MAPS));

  ifs_affine u_ax (
    .m0_i  (lin_sel[0 +: ifs_pkg::SLOT_BITS]),
    .m1_i  (lin_sel[ifs_pkg::SLOT_BITS +: ifs_pkg::SLOT_BITS]),
    .off_i (op_sel[0 +: ifs_pkg::SLOT_BITS]),
    .x_i   (cur_x_q),
    .y_i   (cur_y_q),
    .p_o   (nx)
  );

  ifs_affine u_ay (
    .m0_i  (lin_sel[2*ifs_pkg::SLOT_BITS +: ifs_pkg::SLOT_BITS]),
    .m1_i  (lin_sel[3*ifs_pkg::SLOT_BITS +: ifs_pkg::SLOT_BITS]),
    .off_i (op_sel[ifs_pkg::SLOT_BITS +: ifs_pkg::SLOT_BITS]),
    .x_i   (cur_x_q),
    .y_i   (cur_y_q),
    .p_o   (ny)
  );

  assign emit       = in_valid_q && (cmd_q == ifs_pkg::CMD_STEP) && pick.hit;
  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = in_valid_q && (!emit || out_free);
  assign in_i.ready = !in_valid_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    bmin_x_d  = bmin_x_q;
    bmax_x_d  = bmax_x_q;
    bmin_y_d  = bmin_y_q;
    bmax_y_d  = bmax_y_q;
    started_d = started_q;
    if (advance) begin
      case (cmd_q)
        ifs_pkg::CMD_RESTART: begin
          cur_x_d   = sx_q;
          cur_y_d   = sy_q;
          bmin_x_d  = '0;
          bmax_x_d  = '0;
          bmin_y_d  = '0;
          bmax_y_d  = '0;
          started_d = 1'b0;
        end
        ifs_pkg::CMD_BURN: begin
          if (burn_ok) begin
            cur_x_d = nx;
            cur_y_d = ny;
          end
        end
        ifs_pkg::CMD_STEP: begin
          if (pick.hit) begin
            cur_x_d   = nx;
            cur_y_d   = ny;
            started_d = 1'b1;
            if (!started_q) begin
              bmin_x_d = nx;
              bmax_x_d = nx;
              bmin_y_d = ny;
              bmax_y_d = ny;
            end else begin
              if (nx < bmin_x_q) bmin_x_d = nx;
              if (nx > bmax_x_q) bmax_x_d = nx;
              if (ny < bmin_y_q) bmin_y_d = ny;
              if (ny > bmax_y_q) bmax_y_d = ny;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit && advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      bmin_x_q    <= '0;
      bmax_x_q    <= '0;
      bmin_y_q    <= '0;
      bmax_y_q    <= '0;
      started_q   <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      bmin_x_q    <= bmin_x_d;
      bmax_x_q    <= bmax_x_d;
      bmin_y_q    <= bmin_y_d;
      bmax_y_q    <= bmax_y_d;
      started_q   <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= ifs_pkg::cmd_e'(in_i.command);
      rand_q <= in_i.rand_frac;
      burn_q <= in_i.burn_map;
      sx_q   <= in_i.start_x;
      sy_q   <= in_i.start_y;
    end
    if (emit && advance) begin
      op_x_q   <= nx;
      op_y_q   <= ny;
      oidx_q   <= pick.idx;
      omin_x_q <= bmin_x_d;
      omax_x_q <= bmax_x_d;
      omin_y_q <= bmin_y_d;
      omax_y_q <= bmax_y_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.point_x   = op_x_q;
  assign out_o.point_y   = op_y_q;
  assign out_o.map_index = oidx_q;
  assign out_o.min_x     = omin_x_q;
  assign out_o.max_x     = omax_x_q;
  assign out_o.min_y     = omin_y_q;
  assign out_o.max_y     = omax_y_q;

  assign pt_in_box  = (omin_x_q <= op_x_q) && (op_x_q <= omax_x_q)
                   && (omin_y_q <= op_y_q) && (op_y_q <= omax_y_q);
  assign held       = in_valid_q && !advance;
  assign restart_go = advance && (cmd_q == ifs_pkg::CMD_RESTART);
  assign load_out   = emit && advance;

  `IFS_ASSERT(a_point_in_box, out_valid_q |-> pt_in_box, "result point outside its box")
  `IFS_ASSERT(a_stall_cause, held |-> emit && !out_free, "input word held without a waiting result")
  `IFS_ASSERT(a_restart_clears, restart_go |=> !started_q, "restart left box started")
  `IFS_ASSERT(a_load_source, $rose(out_valid_q) |-> $past(load_out), "result loaded with no step")
  `IFS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !(in_valid_q || out_valid_q), "valid set in reset")

endmodule
